### hdl/sarq_pkg.sv
// Shared types and constants of the shortest-arc quaternion block.
`timescale 1ns / 1ps
`default_nettype none
package sarq_pkg;

   localparam int FieldW        = 16;
   localparam int SumW          = 64;
   localparam int RootW         = 32;
   localparam int ScaleLimitBit = 60;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_SAME     = 2'd0;
   localparam kind_type KIND_OPPOSITE = 2'd1;
   localparam kind_type KIND_GENERAL  = 2'd2;

   typedef struct packed {
      logic signed [FieldW-1:0] from_x;
      logic signed [FieldW-1:0] from_y;
      logic signed [FieldW-1:0] from_z;
      logic signed [FieldW-1:0] to_x;
      logic signed [FieldW-1:0] to_y;
      logic signed [FieldW-1:0] to_z;
   } req_type;

   typedef struct packed {
      logic signed [FieldW-1:0] quat_x;
      logic signed [FieldW-1:0] quat_y;
      logic signed [FieldW-1:0] quat_z;
      logic signed [FieldW-1:0] quat_w;
      kind_type                 case_kind;
      logic                     zero_input;
   } rsp_type;

   typedef struct packed {
      req_type vec;
      logic    zero;
   } cmd_type;

   typedef enum logic [2:0] {
      N_IDLE, N_SQ, N_SCALE, N_SQRT, N_DSET, N_DIV, N_DONE
   } norm_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_NA, B_NB, B_CMP, B_NC, B_NH, B_MUL, B_RND, B_OUT
   } back_state_type;

endpackage
`default_nettype wire

### hdl/sarq_fifo.sv
// Small synchronous queue used between the pipeline parts.
`timescale 1ns / 1ps
`default_nettype none
module sarq_fifo #(
   parameter type T     = logic,
   parameter int  DEPTH = 2
) (
   input  logic clock,
   input  logic reset,
   input  logic wr_en,
   input  T     wr_data,
   output logic full,
   input  logic rd_en,
   output T     rd_data,
   output logic empty
);
   localparam int PW = $clog2(DEPTH);

   T               mem [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]    count_ff;
   logic           do_wr, do_rd;

   assign full    = (count_ff == (PW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_rd) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end
endmodule
`default_nettype wire

### hdl/sarq_front.sv
// Front end: takes vector pairs, flags zero-length inputs, queues them.
`timescale 1ns / 1ps
`default_nettype none
module sarq_front
   import sarq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type req_data,
   output logic    full,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);
   cmd_type entry;
   logic    cmd_empty;

   always_comb begin
      entry.vec  = req_data;
      entry.zero = (req_data.from_x == '0 && req_data.from_y == '0 && req_data.from_z == '0)
                || (req_data.to_x == '0 && req_data.to_y == '0 && req_data.to_z == '0);
   end

   sarq_fifo #(.T(cmd_type), .DEPTH(2)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (entry),
      .full    (full),
      .rd_en   (cmd_pop),
      .rd_data (cmd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = !cmd_empty;
endmodule
`default_nettype wire

### hdl/sarq_norm.sv
// Iterative vector normalizer: sum of squares, scale, bit-serial sqrt, divides.
`timescale 1ns / 1ps
`default_nettype none
module sarq_norm
   import sarq_pkg::*;
#(
   parameter int FRAC_BITS = 14,
   parameter int VW        = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2:0][VW-1:0]           vec,
   output logic                         done,
   output logic [2:0][FRAC_BITS+1:0]    res
);
   localparam int W    = FRAC_BITS + 2;
   localparam int QB   = FRAC_BITS + 1;
   localparam int RW   = RootW + 2;
   localparam int CntW = $clog2(RootW);
   localparam int KW   = $clog2(ScaleLimitBit / 2 + 1);

   norm_state_type   state_ff, state_in;
   logic [VW-1:0]    mag_ff [3];
   logic [2:0]       neg_ff;
   logic [SumW-1:0]  prod_ff, sum_ff, root_ff, bit_ff, dvd_ff;
   logic [KW-1:0]    k_ff;
   logic [CntW-1:0]  cnt_ff;
   logic [1:0]       comp_ff;
   logic [RW-1:0]    rem_ff;
   logic [QB-1:0]    quo_ff;
   logic [2:0][W-1:0] res_ff;

   logic             load;
   logic [1:0]       sq_idx;
   logic [2*VW-1:0]  sq;
   logic [SumW-1:0]  num, dividend, root_bit;
   logic [RootW:0]   divisor;
   logic [RW-1:0]    trial;
   logic             take;
   logic [QB-1:0]    quo_next, quo_clamp;

   assign load     = start && (state_ff == N_IDLE || state_ff == N_DONE);
   assign sq_idx   = (cnt_ff[1:0] == 2'd3) ? 2'd0 : cnt_ff[1:0];
   assign sq       = mag_ff[sq_idx] * mag_ff[sq_idx];
   assign root_bit = root_ff + bit_ff;
   assign num      = (SumW'(mag_ff[comp_ff]) << k_ff) << FRAC_BITS;
   assign dividend = (num << 1) + root_ff;
   assign divisor  = {root_ff[RootW-1:0], 1'b0};
   assign trial    = {rem_ff[RW-2:0], dvd_ff[SumW-1]};
   assign take     = (trial >= RW'(divisor));
   assign quo_next = {quo_ff[QB-2:0], take};
   assign quo_clamp = (quo_next > (QB'(1) << FRAC_BITS)) ? (QB'(1) << FRAC_BITS) : quo_next;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         N_IDLE:  if (load) state_in = N_SQ;
         N_SQ:    if (cnt_ff == CntW'(3)) state_in = N_SCALE;
         N_SCALE: begin
            if (sum_ff == '0) state_in = N_DONE;
            else if (sum_ff[SumW-1:ScaleLimitBit] != '0) state_in = N_SQRT;
         end
         N_SQRT:  if (bit_ff[0]) state_in = N_DSET;
         N_DSET:  state_in = N_DIV;
         N_DIV: begin
            if (cnt_ff == CntW'(QB-1)) state_in = (comp_ff == 2'd2) ? N_DONE : N_DSET;
         end
         N_DONE:  state_in = load ? N_SQ : N_IDLE;
         default: state_in = N_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = (state_ff == N_DONE);
      res  = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= N_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i] <= vec[i][VW-1] ? (~vec[i] + 1'b1) : vec[i];
            neg_ff[i] <= vec[i][VW-1];
         end
         cnt_ff  <= '0;
         sum_ff  <= '0;
         k_ff    <= '0;
         comp_ff <= '0;
      end else begin
         case (state_ff)
            N_SQ: begin
               prod_ff <= SumW'(sq);
               if (cnt_ff != '0) sum_ff <= sum_ff + prod_ff;
               cnt_ff <= cnt_ff + 1'b1;
            end
            N_SCALE: begin
               if (sum_ff == '0) begin
                  res_ff <= '0;
               end else if (sum_ff[SumW-1:ScaleLimitBit] == '0) begin
                  sum_ff <= sum_ff << 2;
                  k_ff   <= k_ff + 1'b1;
               end else begin
                  root_ff <= '0;
                  bit_ff  <= SumW'(1) << (SumW - 2);
               end
            end
            N_SQRT: begin
               if (sum_ff >= root_bit) begin
                  sum_ff  <= sum_ff - root_bit;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
            end
            N_DSET: begin
               dvd_ff <= dividend << (SumW - QB);
               rem_ff <= RW'(dividend >> QB);
               quo_ff <= '0;
               cnt_ff <= '0;
            end
            N_DIV: begin
               rem_ff <= take ? (trial - RW'(divisor)) : trial;
               dvd_ff <= dvd_ff << 1;
               quo_ff <= quo_next;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CntW'(QB-1)) begin
                  res_ff[comp_ff] <= neg_ff[comp_ff] ? -W'(quo_clamp) : W'(quo_clamp);
                  comp_ff <= comp_ff + 1'b1;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### hdl/sarq_back.sv
// Back end: sequences normalizations, case tests and the cross/dot products.
`timescale 1ns / 1ps
`default_nettype none
module sarq_back
   import sarq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [9:0] tol,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   input  logic       out_full,
   output logic       out_push,
   output rsp_type    out_data
);
   localparam int W  = FRAC_BITS + 2;
   localparam int VW = (FRAC_BITS + 3 > FieldW) ? FRAC_BITS + 3 : FieldW;
   localparam int PW = 2 * W;
   localparam int AW = 2 * W + 2;

   back_state_type       state_ff, state_in;
   req_type              vec_ff;
   logic signed [W-1:0]  f_ff [3];
   logic signed [W-1:0]  t_ff [3];
   logic signed [W-1:0]  h_ff [3];
   logic signed [W-1:0]  q_ff [4];
   kind_type             kind_ff;
   logic                 zero_ff;
   logic [3:0]           cnt_ff;
   logic signed [PW-1:0] prod_ff;
   logic signed [AW-1:0] acc_ff [4];
   logic [1:0]           pend_g_ff;
   logic                 pend_sub_ff;

   logic                 norm_start, norm_done;
   logic [2:0][VW-1:0]   norm_vec;
   logic [2:0][W-1:0]    norm_res;
   logic                 is_eq, is_opp, sel_y, sel_z;
   logic [W-1:0]         af [3];
   logic [1:0]           mul_a, mul_b, mul_g;
   logic                 mul_sub;

   function automatic logic signed [W-1:0] qround(input logic signed [AW-1:0] x);
      logic [AW-1:0] m;
      logic [AW-1:0] r;
      m = x[AW-1] ? (~x + 1'b1) : x;
      r = (m + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (r > (AW'(1) << FRAC_BITS)) r = AW'(1) << FRAC_BITS;
      return x[AW-1] ? -W'(r) : W'(r);
   endfunction

   // equal / opposite tests and smallest-axis choice
   always_comb begin
      logic signed [W:0] dm, dp;
      logic [W:0]        adm, adp;
      is_eq  = 1'b1;
      is_opp = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dm  = (W+1)'(f_ff[i]) - (W+1)'(t_ff[i]);
         dp  = (W+1)'(f_ff[i]) + (W+1)'(t_ff[i]);
         adm = dm[W] ? (~dm + 1'b1) : dm;
         adp = dp[W] ? (~dp + 1'b1) : dp;
         if (adm > (W+1)'(tol)) is_eq  = 1'b0;
         if (adp > (W+1)'(tol)) is_opp = 1'b0;
         af[i] = f_ff[i][W-1] ? (~f_ff[i] + 1'b1) : f_ff[i];
      end
      sel_y = af[1] < af[0];
      sel_z = (af[2] < af[1]) && (af[2] < af[0]);
   end

   // product schedule: three cross terms in pairs, then the dot product
   always_comb begin
      mul_a = 2'd0; mul_b = 2'd0; mul_g = 2'd3; mul_sub = 1'b0;
      case (cnt_ff)
         4'd0: begin mul_a = 2'd1; mul_b = 2'd2; mul_g = 2'd0; end
         4'd1: begin mul_a = 2'd2; mul_b = 2'd1; mul_g = 2'd0; mul_sub = 1'b1; end
         4'd2: begin mul_a = 2'd2; mul_b = 2'd0; mul_g = 2'd1; end
         4'd3: begin mul_a = 2'd0; mul_b = 2'd2; mul_g = 2'd1; mul_sub = 1'b1; end
         4'd4: begin mul_a = 2'd0; mul_b = 2'd1; mul_g = 2'd2; end
         4'd5: begin mul_a = 2'd1; mul_b = 2'd0; mul_g = 2'd2; mul_sub = 1'b1; end
         4'd6: begin mul_a = 2'd0; mul_b = 2'd0; end
         4'd7: begin mul_a = 2'd1; mul_b = 2'd1; end
         4'd8: begin mul_a = 2'd2; mul_b = 2'd2; end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (cmd_valid) state_in = cmd.zero ? B_OUT : B_NA;
         B_NA:   if (norm_done) state_in = B_NB;
         B_NB:   if (norm_done) state_in = B_CMP;
         B_CMP: begin
            if (is_eq)       state_in = B_OUT;
            else if (is_opp) state_in = B_NC;
            else             state_in = B_NH;
         end
         B_NC:   if (norm_done) state_in = B_OUT;
         B_NH:   if (norm_done) state_in = B_MUL;
         B_MUL:  if (cnt_ff == 4'd9) state_in = B_RND;
         B_RND:  state_in = B_OUT;
         B_OUT:  if (!out_full) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd_pop    = (state_ff == B_IDLE) && cmd_valid;
      out_push   = (state_ff == B_OUT) && !out_full;
      norm_start = 1'b0;
      norm_vec   = '0;
      unique case (state_ff)
         B_IDLE: begin
            norm_start  = cmd_valid && !cmd.zero;
            norm_vec[0] = VW'(cmd.vec.from_x);
            norm_vec[1] = VW'(cmd.vec.from_y);
            norm_vec[2] = VW'(cmd.vec.from_z);
         end
         B_NA: begin
            norm_start  = norm_done;
            norm_vec[0] = VW'(vec_ff.to_x);
            norm_vec[1] = VW'(vec_ff.to_y);
            norm_vec[2] = VW'(vec_ff.to_z);
         end
         B_CMP: begin
            norm_start = !is_eq;
            if (is_opp) begin
               if (sel_z) begin
                  norm_vec[0] = VW'(f_ff[1]);
                  norm_vec[1] = -VW'(f_ff[0]);
               end else if (sel_y) begin
                  norm_vec[0] = -VW'(f_ff[2]);
                  norm_vec[2] = VW'(f_ff[0]);
               end else begin
                  norm_vec[1] = VW'(f_ff[2]);
                  norm_vec[2] = -VW'(f_ff[1]);
               end
            end else begin
               for (int i = 0; i < 3; i++) norm_vec[i] = VW'(f_ff[i]) + VW'(t_ff[i]);
            end
         end
         default: ;
      endcase
      out_data.quat_x     = FieldW'(q_ff[0]);
      out_data.quat_y     = FieldW'(q_ff[1]);
      out_data.quat_z     = FieldW'(q_ff[2]);
      out_data.quat_w     = FieldW'(q_ff[3]);
      out_data.case_kind  = kind_ff;
      out_data.zero_input = zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= B_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            vec_ff  <= cmd.vec;
            zero_ff <= cmd.zero;
            kind_ff <= KIND_SAME;
            for (int i = 0; i < 3; i++) q_ff[i] <= '0;
            q_ff[3] <= W'(1) << FRAC_BITS;
         end
         B_NA: if (norm_done) for (int i = 0; i < 3; i++) f_ff[i] <= $signed(norm_res[i]);
         B_NB: if (norm_done) for (int i = 0; i < 3; i++) t_ff[i] <= $signed(norm_res[i]);
         B_CMP: begin
            if (!is_eq) kind_ff <= is_opp ? KIND_OPPOSITE : KIND_GENERAL;
            cnt_ff <= '0;
            for (int i = 0; i < 4; i++) acc_ff[i] <= '0;
         end
         B_NC: begin
            if (norm_done) begin
               for (int i = 0; i < 3; i++) q_ff[i] <= $signed(norm_res[i]);
               q_ff[3] <= '0;
            end
         end
         B_NH: if (norm_done) for (int i = 0; i < 3; i++) h_ff[i] <= $signed(norm_res[i]);
         B_MUL: begin
            prod_ff     <= PW'(f_ff[mul_a]) * PW'(h_ff[mul_b]);
            pend_g_ff   <= mul_g;
            pend_sub_ff <= mul_sub;
            if (cnt_ff != '0) begin
               acc_ff[pend_g_ff] <= pend_sub_ff ? acc_ff[pend_g_ff] - AW'(prod_ff)
                                                : acc_ff[pend_g_ff] + AW'(prod_ff);
            end
            cnt_ff <= cnt_ff + 1'b1;
         end
         B_RND: for (int i = 0; i < 4; i++) q_ff[i] <= qround(acc_ff[i]);
         default: ;
      endcase
   end

   sarq_norm #(.FRAC_BITS(FRAC_BITS), .VW(VW)) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .vec   (norm_vec),
      .done  (norm_done),
      .res   (norm_res)
   );
endmodule
`default_nettype wire

### hdl/shortest_arc_quaternion.sv
// Top level of the shortest-arc rotation quaternion unit.
`timescale 1ns / 1ps
`default_nettype none
// Shortest-arc rotation quaternion: for each transfer of a source and a target
// vector (any common scale, 16-bit signed) the block returns the unit quaternion
// in Q1.FRAC_BITS that turns the source onto the target, plus a case code
// (same, opposite, general) and a zero-length flag. Both sides are queues: an
// item is taken on push while full is low, a result leaves on pop while empty
// is low. The front end flags zero-length pairs and buffers up to two of them, so
// input transfers go back to back until its queue fills; a two-deep
// result queue lets the back end finish an item while the previous result waits.
// Throughput is set by the one shared normalizer (sum of squares, k = 0..30
// scaling steps, a 32-step bit-serial square root and three restoring divides
// of FRAC_BITS+1 steps); the back end works on one pair at a time.
// A same-direction pair needs two normalizations, an opposite pair three, and
// a general pair three plus nine products on one multiplier and the rounding.
// A pair with a zero-length vector goes from the front queue to the result side
// without any normalization. The eq_tolerance register (csr_wdata, reset 1) is
// written with csr_we and should only change while no item is in flight.
module shortest_arc_quaternion
   import sarq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  req_type    req_data,
   output logic       full,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [9:0] csr_wdata
);
   logic [9:0] tol_ff;
   logic       cmd_valid, cmd_pop;
   cmd_type    cmd;
   logic       out_full, out_push;
   rsp_type    out_data;

   // tolerance register for the equal / opposite tests
   always_ff @(posedge clock) begin
      if (reset)       tol_ff <= 10'd1;
      else if (csr_we) tol_ff <= csr_wdata;
   end

   sarq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .req_data  (req_data),
      .full      (full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   sarq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .tol       (tol_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // result queue decouples the back end from the consumer
   sarq_fifo #(.T(rsp_type), .DEPTH(2)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (out_push),
      .wr_data (out_data),
      .full    (out_full),
      .rd_en   (pop),
      .rd_data (rsp_data),
      .empty   (empty)
   );
endmodule
`default_nettype wire

### hdl/sarq_checker.sv
// Port-level checks of the quaternion unit and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sarq_checker
   import sarq_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input logic    clock,
   input logic    reset,
   input logic    empty,
   input rsp_type rsp_data
);
   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_zero_identity: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.zero_input) |->
         (rsp_data.quat_x == '0 && rsp_data.quat_y == '0 && rsp_data.quat_z == '0 &&
          rsp_data.quat_w == FieldW'(64'd1 << FRAC_BITS) &&
          rsp_data.case_kind == KIND_SAME))
      else $error("zero-length input did not give identity");

   a_same_identity: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.case_kind == KIND_SAME) |->
         (rsp_data.quat_x == '0 && rsp_data.quat_y == '0 && rsp_data.quat_z == '0))
      else $error("same-direction result has nonzero axis");

   a_opposite_w: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.case_kind == KIND_OPPOSITE) |->
         (rsp_data.quat_w == '0 && !rsp_data.zero_input))
      else $error("half-turn result has nonzero w");
endmodule

bind shortest_arc_quaternion sarq_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);
`default_nettype wire
